@@ sv/nvta_pkg.sv @@
// shared types and constants of the note voice track allocator
// no dependencies; every other file imports this package
package nvta_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int MAX_TRACKS = 64;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int TRK_W      = 6;

   localparam logic [7:0] CSR_NOTE_OFF = 8'd0;
   localparam logic [7:0] CSR_NOTE_CUT = 8'd1;

   localparam logic [1:0] MODE_GLOBAL = 2'd1;
   localparam logic [1:0] MODE_TRACK  = 2'd2;

   localparam logic signed [2:0] GROUP_NONE = -3'sd1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN_RD,
      CMD_SCAN_EV,
      CMD_DECIDE,
      CMD_FREE_STEP,
      CMD_CMP_RD,
      CMD_CMP_EV,
      CMD_CMP_DONE,
      CMD_PUSH,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic trk_mode;
      logic is_off;
      logic scan_done;
      logic cmp_done;
      logic free_hit;
      logic free_last;
      logic have_old;
   } status_type;

   typedef struct packed {
      logic [7:0]       inst;
      logic [1:0]       grp;
      logic [TRK_W-1:0] trk;
      logic [7:0]       note;
   } entry_type;

endpackage

@@ sv/nvta_ctrl.sv @@
// sequencer of the allocator: scan, free-track search, compaction, push, emit
// depends on nvta_pkg; drives nvta_dpath through command and status
module nvta_ctrl import nvta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_DECIDE, ST_FREE,
      ST_CMP_RD, ST_CMP_EV, ST_PUSH, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end else begin
               cmd      = CMD_SCAN_RD;
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            cmd      = CMD_SCAN_EV;
            state_in = ST_SCAN_RD;
         end
         ST_DECIDE: begin
            cmd = CMD_DECIDE;
            if (status.skip || !status.trk_mode) state_in = ST_EMIT;
            else if (status.is_off)              state_in = ST_CMP_RD;
            else                                 state_in = ST_FREE;
         end
         ST_FREE: begin
            cmd = CMD_FREE_STEP;
            if (status.free_hit)       state_in = ST_PUSH;
            else if (status.free_last) state_in = status.have_old ? ST_CMP_RD : ST_PUSH;
         end
         ST_CMP_RD: begin
            if (status.cmp_done) begin
               cmd      = CMD_CMP_DONE;
               state_in = status.is_off ? ST_EMIT : ST_PUSH;
            end else begin
               cmd      = CMD_CMP_RD;
               state_in = ST_CMP_EV;
            end
         end
         ST_CMP_EV: begin
            cmd      = CMD_CMP_EV;
            state_in = ST_CMP_RD;
         end
         ST_PUSH: begin
            cmd      = CMD_PUSH;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd      = CMD_EMIT;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

@@ sv/nvta_dpath.sv @@
// datapath of the allocator: note list memory, scan state, result registers
// depends on nvta_pkg; commanded by nvta_ctrl
module nvta_dpath import nvta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [7:0]        req_plugin_id,
   input  logic [7:0]        req_note,
   input  logic signed [8:0] req_prev_note,
   input  logic [1:0]        req_group_mode,
   input  logic [6:0]        req_track_count,
   input  logic [5:0]        req_note_column,
   input  logic [5:0]        req_velocity_column,
   input  logic              csr_valid,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output logic              rsp_strobe,
   output logic              rsp_accepted,
   output logic signed [2:0] rsp_out_group,
   output logic [5:0]        rsp_out_track,
   output logic [5:0]        rsp_out_note_column,
   output logic [5:0]        rsp_out_velocity_column,
   output logic              rsp_overflow
);

   // captured item
   logic [7:0]        pid_ff, note_ff;
   logic signed [8:0] prev_ff;
   logic [1:0]        mode_ff;
   logic [6:0]        tracks_ff;
   logic [5:0]        ncol_in_ff, vcol_in_ff;
   // configuration
   logic [7:0]        off_code_ff, cut_code_ff;
   // list and scan state
   entry_type         mem [LIST_DEPTH];
   entry_type         rdata_ff;
   logic [CNT_W-1:0]  count_ff, idx_ff, wp_ff;
   logic [TRK_W-1:0]  t_ff, old_trk_ff;
   logic [IDX_W-1:0]  old_idx_ff;
   logic [(2**TRK_W)-1:0] used_ff;
   logic              have_old_ff, match_ff, removed_ff;
   // result
   logic              acc_ff, ovf_ff;
   logic signed [2:0] grp_ff;
   logic [5:0]        trk_ff, ncol_ff, vcol_ff;
   logic              strobe_ff;
   logic              acc_o_ff, ovf_o_ff;
   logic signed [2:0] grp_o_ff;
   logic [5:0]        trk_o_ff, ncol_o_ff, vcol_o_ff;

   logic              is_off, prev_all, hit, own, remove, full;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   // decode of item and current entry
   assign is_off   = (note_ff == off_code_ff) || (note_ff == cut_code_ff);
   assign prev_all = (prev_ff == -9'sd1);
   assign own      = (rdata_ff.inst == pid_ff);
   assign hit      = own && (prev_all || (!prev_ff[8] && rdata_ff.note == prev_ff[7:0]));
   assign remove   = (mode_ff == MODE_TRACK && !is_off) ?
                     (idx_ff[IDX_W-1:0] == old_idx_ff) : (hit && (prev_all || !removed_ff));
   assign full     = (count_ff == CNT_W'(LIST_DEPTH));

   assign status.skip      = (is_off && !prev_all && !match_ff) || (mode_ff == 2'd0) ||
                             (mode_ff == 2'd3);
   assign status.trk_mode  = (mode_ff == MODE_TRACK);
   assign status.is_off    = is_off;
   assign status.scan_done = (idx_ff == count_ff);
   assign status.cmp_done  = (idx_ff == count_ff);
   assign status.free_hit  = !used_ff[t_ff];
   assign status.free_last = ({1'b0, t_ff} == tracks_ff - 7'd1);
   assign status.have_old  = have_old_ff;

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rdata_ff;
      case (cmd)
         CMD_CMP_EV: begin
            wr_en   = !remove;
            wr_addr = wp_ff[IDX_W-1:0];
         end
         CMD_DECIDE: begin
            wr_en   = !status.skip && mode_ff == MODE_GLOBAL && !is_off;
            wr_data = '{inst: pid_ff, grp: MODE_GLOBAL, trk: '0, note: note_ff};
         end
         CMD_PUSH: begin
            wr_en   = !full;
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = '{inst: pid_ff, grp: MODE_TRACK, trk: trk_ff, note: note_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd == CMD_SCAN_RD || cmd == CMD_CMP_RD) rdata_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         off_code_ff <= 8'd255;
         cut_code_ff <= 8'd254;
      end else if (csr_valid) begin
         if (csr_index == CSR_NOTE_OFF) off_code_ff <= csr_wdata;
         if (csr_index == CSR_NOTE_CUT) cut_code_ff <= csr_wdata;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         pid_ff     <= req_plugin_id;
         note_ff    <= req_note;
         prev_ff    <= req_prev_note;
         mode_ff    <= req_group_mode;
         ncol_in_ff <= req_note_column;
         vcol_in_ff <= req_velocity_column;
         if (req_track_count == 7'd0)                    tracks_ff <= 7'd1;
         else if (req_track_count > 7'(MAX_TRACKS))      tracks_ff <= 7'(MAX_TRACKS);
         else                                            tracks_ff <= req_track_count;
      end
   end

   // list control and result
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         idx_ff    <= '0;
         wp_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd == CMD_EMIT);
         case (cmd)
            CMD_LOAD: begin
               acc_ff      <= 1'b0;
               ovf_ff      <= 1'b0;
               grp_ff      <= GROUP_NONE;
               trk_ff      <= '0;
               ncol_ff     <= '0;
               vcol_ff     <= '0;
               idx_ff      <= '0;
               used_ff     <= '0;
               have_old_ff <= 1'b0;
               match_ff    <= 1'b0;
               removed_ff  <= 1'b0;
            end
            CMD_SCAN_EV: begin
               if (hit) match_ff <= 1'b1;
               if (own && {1'b0, rdata_ff.trk} < tracks_ff) begin
                  used_ff[rdata_ff.trk] <= 1'b1;
                  if (!have_old_ff) begin
                     have_old_ff <= 1'b1;
                     old_idx_ff  <= idx_ff[IDX_W-1:0];
                     old_trk_ff  <= rdata_ff.trk;
                  end
               end
               idx_ff <= idx_ff + 1'b1;
            end
            CMD_DECIDE: begin
               idx_ff <= '0;
               wp_ff  <= '0;
               t_ff   <= '0;
               if (!status.skip) begin
                  ncol_ff <= ncol_in_ff;
                  vcol_ff <= vcol_in_ff;
                  trk_ff  <= '0;
                  if (mode_ff == MODE_TRACK) begin
                     grp_ff <= 3'sd2;
                  end else begin
                     grp_ff <= 3'sd1;
                     if (!is_off) begin
                        count_ff <= CNT_W'(1);
                        acc_ff   <= 1'b1;
                     end else if (match_ff) begin
                        count_ff <= '0;
                        acc_ff   <= 1'b1;
                     end
                  end
               end
            end
            CMD_FREE_STEP: begin
               if (status.free_hit)       trk_ff <= t_ff;
               else if (status.free_last) trk_ff <= old_trk_ff;
               t_ff <= t_ff + 1'b1;
            end
            CMD_CMP_EV: begin
               if (remove) begin
                  removed_ff <= 1'b1;
                  if (is_off) begin
                     grp_ff <= $signed({1'b0, rdata_ff.grp});
                     trk_ff <= rdata_ff.trk;
                     if (!prev_all) acc_ff <= 1'b1;
                  end
               end else begin
                  wp_ff <= wp_ff + 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
            end
            CMD_CMP_DONE: count_ff <= wp_ff;
            CMD_PUSH: begin
               acc_ff <= 1'b1;
               if (full) ovf_ff   <= 1'b1;
               else      count_ff <= count_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // result beat registers
   always_ff @(posedge clock) begin
      if (cmd == CMD_EMIT) begin
         acc_o_ff  <= acc_ff;
         ovf_o_ff  <= ovf_ff;
         grp_o_ff  <= grp_ff;
         trk_o_ff  <= trk_ff;
         ncol_o_ff <= ncol_ff;
         vcol_o_ff <= vcol_ff;
      end
   end

   assign rsp_strobe              = strobe_ff;
   assign rsp_accepted            = acc_o_ff;
   assign rsp_overflow            = ovf_o_ff;
   assign rsp_out_group           = grp_o_ff;
   assign rsp_out_track           = trk_o_ff;
   assign rsp_out_note_column     = ncol_o_ff;
   assign rsp_out_velocity_column = vcol_o_ff;

endmodule

@@ sv/note_voice_track_allocator.sv @@
// Note voice track allocator with oldest-note stealing.
// Request: drive req_* and raise start; the beat is taken at an edge where
// start is high and busy is low. busy stays high until the result is out.
// Result: one beat per request on rsp_*, marked by rsp_strobe for exactly
// one cycle; the receiver cannot stall, so it must sample that cycle.
// Configuration: csr_valid/csr_ready write note_off_code (index 0) and
// note_cut_code (index 1); csr_ready is always high. Write only when idle.
// Sequence: every request scans the list, each stored entry taking a
// memory read, then an evaluate step, a pace set by the single read port of
// the list memory. A release in per-track mode adds a compaction pass over
// the entries; a per-track note-on adds a search step per track searched
// and, when stealing, a compaction pass.
// Reset empties the list (its fill count is cleared, no clearing pass) and
// restores the off code 255 and cut code 254.
// depends on nvta_pkg, nvta_ctrl and nvta_dpath
module note_voice_track_allocator import nvta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [7:0]        req_plugin_id,
   input  logic [7:0]        req_note,
   input  logic signed [8:0] req_prev_note,
   input  logic [1:0]        req_group_mode,
   input  logic [6:0]        req_track_count,
   input  logic [5:0]        req_note_column,
   input  logic [5:0]        req_velocity_column,
   output logic              rsp_strobe,
   output logic              rsp_accepted,
   output logic signed [2:0] rsp_out_group,
   output logic [5:0]        rsp_out_track,
   output logic [5:0]        rsp_out_note_column,
   output logic [5:0]        rsp_out_velocity_column,
   output logic              rsp_overflow,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   nvta_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   nvta_dpath u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_plugin_id           (req_plugin_id),
      .req_note                (req_note),
      .req_prev_note           (req_prev_note),
      .req_group_mode          (req_group_mode),
      .req_track_count         (req_track_count),
      .req_note_column         (req_note_column),
      .req_velocity_column     (req_velocity_column),
      .csr_valid               (csr_valid),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .rsp_strobe              (rsp_strobe),
      .rsp_accepted            (rsp_accepted),
      .rsp_out_group           (rsp_out_group),
      .rsp_out_track           (rsp_out_track),
      .rsp_out_note_column     (rsp_out_note_column),
      .rsp_out_velocity_column (rsp_out_velocity_column),
      .rsp_overflow            (rsp_overflow)
   );

endmodule

@@ sv/nvta_checker.sv @@
// port-level checks of the allocator, bound to the top level
// depends on nvta_pkg and note_voice_track_allocator
module nvta_checker import nvta_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic              rsp_accepted,
   input logic signed [2:0] rsp_out_group,
   input logic [5:0]        rsp_out_track,
   input logic [5:0]        rsp_out_note_column,
   input logic              rsp_overflow
);

   // a taken request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after request");

   // a result beat only follows a busy period
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result beat without request");

   // one beat per request, never two in a row
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("repeated result beat");

   // no target group means nothing placed and zeroed fields
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_group == GROUP_NONE |->
      !rsp_accepted && rsp_out_track == 6'd0 && rsp_out_note_column == 6'd0)
      else $error("bad result with no group");

   // a dropped push is a per-track note-on
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_overflow |-> rsp_accepted && rsp_out_group == 3'sd2)
      else $error("overflow outside per-track note-on");

endmodule

bind note_voice_track_allocator nvta_checker u_nvta_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_accepted        (rsp_accepted),
   .rsp_out_group       (rsp_out_group),
   .rsp_out_track       (rsp_out_track),
   .rsp_out_note_column (rsp_out_note_column),
   .rsp_overflow        (rsp_overflow)
);

@@ sim/note_voice_track_allocator_tb.sv @@
// testbench of note_voice_track_allocator: directed and random note events
// checked beat by beat against a behavioral voice list kept here
// depends on nvta_pkg and the allocator RTL
`timescale 1ns / 1ps

module note_voice_track_allocator_tb;
   import nvta_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct {
      logic              acc;
      logic signed [2:0] grp;
      logic [5:0]        trk;
      logic [5:0]        ncol;
      logic [5:0]        vcol;
      logic              ovf;
   } voice_result_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [7:0]        req_plugin_id;
   logic [7:0]        req_note;
   logic signed [8:0] req_prev_note;
   logic [1:0]        req_group_mode;
   logic [6:0]        req_track_count;
   logic [5:0]        req_note_column;
   logic [5:0]        req_velocity_column;
   logic              rsp_strobe;
   logic              rsp_accepted;
   logic signed [2:0] rsp_out_group;
   logic [5:0]        rsp_out_track;
   logic [5:0]        rsp_out_note_column;
   logic [5:0]        rsp_out_velocity_column;
   logic              rsp_overflow;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_index;
   logic [7:0]        csr_wdata;

   // voice list model, oldest first, and its code registers
   entry_type        voice_list[$];
   logic [7:0]       off_code;
   logic [7:0]       cut_code;
   voice_result_type pending_results[$];

   int  mismatch_count;
   int  item_count;
   int  result_count;
   int  overflow_count;
   bit  idle_enable;
   int  quiet_cycles;

   note_voice_track_allocator DUT (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // voice allocation for one accepted beat, updates the list
   function automatic voice_result_type allocate_voice(logic [7:0] pid, logic [7:0] note,
                                                       logic signed [8:0] rel_note,
                                                       logic [1:0] mode, logic [6:0] tc,
                                                       logic [5:0] ncol, logic [5:0] vcol);
      voice_result_type r;
      bit               is_off;
      bit               sounding;
      int               prev;
      int               i;
      int               tracks;
      int               t;
      bit               used[MAX_TRACKS];
      bit               have_old;
      int               old_idx;
      int               old_trk;
      bit               found;
      entry_type        e;
      r = '{acc: 1'b0, grp: GROUP_NONE, trk: '0, ncol: '0, vcol: '0, ovf: 1'b0};
      prev = int'(rel_note);
      is_off = (note == off_code) || (note == cut_code);
      sounding = 1'b0;
      if (prev >= 0)
         foreach (voice_list[k])
            if (voice_list[k].inst == pid && int'(voice_list[k].note) == prev)
               sounding = 1'b1;
      if (is_off && prev != -1 && !sounding) return r;
      if (mode != MODE_GLOBAL && mode != MODE_TRACK) return r;
      r.ncol = ncol;
      r.vcol = vcol;
      if (mode == MODE_TRACK) begin
         r.grp = 3'sd2;
         if (is_off) begin
            // release matching notes, one or all of the instrument
            i = 0;
            while (i < voice_list.size()) begin
               if (voice_list[i].inst == pid &&
                   (prev == -1 || int'(voice_list[i].note) == prev)) begin
                  r.grp = $signed({1'b0, voice_list[i].grp});
                  r.trk = voice_list[i].trk;
                  voice_list.delete(i);
                  if (prev != -1) begin
                     r.acc = 1'b1;
                     return r;
                  end
               end else begin
                  i++;
               end
            end
         end else begin
            // lowest free track, else steal the oldest
            tracks = (tc < 1) ? 1 : (tc > MAX_TRACKS) ? MAX_TRACKS : int'(tc);
            foreach (used[k]) used[k] = 1'b0;
            have_old = 1'b0;
            old_idx = 0;
            old_trk = 0;
            foreach (voice_list[k]) begin
               if (voice_list[k].inst == pid && int'(voice_list[k].trk) < tracks) begin
                  used[voice_list[k].trk] = 1'b1;
                  if (!have_old) begin
                     have_old = 1'b1;
                     old_idx = k;
                     old_trk = int'(voice_list[k].trk);
                  end
               end
            end
            found = 1'b0;
            for (t = 0; t < tracks; t++)
               if (!used[t]) begin
                  found = 1'b1;
                  break;
               end
            if (!found) begin
               t = old_trk;
               if (have_old) voice_list.delete(old_idx);
            end
            r.trk = t[5:0];
            if (voice_list.size() >= LIST_DEPTH) begin
               r.ovf = 1'b1;
            end else begin
               e = '{inst: pid, grp: MODE_TRACK, trk: t[5:0], note: note};
               voice_list.insert(voice_list.size(), e);
            end
            r.acc = 1'b1;
         end
      end else begin
         r.grp = 3'sd1;
         if (is_off) begin
            foreach (voice_list[k])
               if (voice_list[k].inst == pid &&
                   (prev == -1 || int'(voice_list[k].note) == prev)) begin
                  r.acc = 1'b1;
                  break;
               end
            if (r.acc) voice_list.delete();
         end else begin
            voice_list.delete();
            e = '{inst: pid, grp: MODE_GLOBAL, trk: '0, note: note};
            voice_list.insert(voice_list.size(), e);
            r.acc = 1'b1;
         end
      end
      return r;
   endfunction

   // send one note beat; start stays high into the next beat unless idling
   task automatic send_note(input logic [7:0] pid, input logic [7:0] note,
                            input logic signed [8:0] rel_note, input logic [1:0] mode,
                            input logic [6:0] tc, input logic [5:0] ncol,
                            input logic [5:0] vcol);
      int gap;
      voice_result_type r;
      gap = 0;
      if (idle_enable && $urandom_range(99) < 25) gap = $urandom_range(6, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_plugin_id       <= pid;
      req_note            <= note;
      req_prev_note       <= rel_note;
      req_group_mode      <= mode;
      req_track_count     <= tc;
      req_note_column     <= ncol;
      req_velocity_column <= vcol;
      do @(posedge clock); while (busy);
      r = allocate_voice(pid, note, rel_note, mode, tc, ncol, vcol);
      if (r.ovf) overflow_count++;
      pending_results.insert(pending_results.size(), r);
      item_count++;
   endtask

   // let the block drain before a register write or the end
   task automatic drain_block();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_code(input logic [7:0] index, input logic [7:0] value);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_NOTE_OFF) off_code = value;
      else if (index == CSR_NOTE_CUT) cut_code = value;
      @(posedge clock);
   endtask

   // random sounding note of an instrument, -1 when it has none
   function automatic int sounding_note(logic [7:0] pid);
      int hits[$];
      foreach (voice_list[k])
         if (voice_list[k].inst == pid) hits.insert(hits.size(), int'(voice_list[k].note));
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   // note-on value that is not an off or cut code
   function automatic logic [7:0] play_note();
      logic [7:0] n;
      do n = 8'($urandom); while (n == off_code || n == cut_code);
      return n;
   endfunction

   task automatic test_directed();
      // disabled and undefined modes, field extremes
      send_note(8'd0, 8'd0, 9'sd0, 2'd0, 7'd0, 6'd0, 6'd0);
      send_note(8'd255, 8'd255, -9'sd256, 2'd3, 7'd127, 6'd63, 6'd63);
      // per-track note-ons with track count saturation
      send_note(8'd0, 8'd10, 9'sd0, MODE_TRACK, 7'd0, 6'd63, 6'd0);
      send_note(8'd0, 8'd11, 9'sd0, MODE_TRACK, 7'd0, 6'd1, 6'd2);
      send_note(8'd255, 8'd20, 9'sd255, MODE_TRACK, 7'd127, 6'd0, 6'd63);
      send_note(8'd255, 8'd21, -9'sd1, MODE_TRACK, 7'd2, 6'd5, 6'd5);
      // note-off of a note not sounding, odd negative prev
      send_note(8'd255, off_code, 9'sd99, MODE_TRACK, 7'd2, 6'd3, 6'd3);
      send_note(8'd255, cut_code, -9'sd256, MODE_TRACK, 7'd2, 6'd3, 6'd3);
      // matching note-off and note-cut
      send_note(8'd255, off_code, 9'sd20, MODE_TRACK, 7'd2, 6'd7, 6'd8);
      send_note(8'd0, cut_code, 9'sd11, MODE_TRACK, 7'd1, 6'd7, 6'd8);
      // release all, then release all with nothing left
      send_note(8'd255, off_code, -9'sd1, MODE_TRACK, 7'd2, 6'd9, 6'd9);
      send_note(8'd255, off_code, -9'sd1, MODE_TRACK, 7'd2, 6'd9, 6'd9);
      // entries on high tracks neither block nor get stolen
      send_note(8'd3, 8'd30, 9'sd0, MODE_TRACK, 7'd4, 6'd1, 6'd1);
      send_note(8'd3, 8'd31, 9'sd0, MODE_TRACK, 7'd4, 6'd1, 6'd1);
      send_note(8'd3, 8'd32, 9'sd0, MODE_TRACK, 7'd4, 6'd1, 6'd1);
      send_note(8'd3, 8'd33, 9'sd0, MODE_TRACK, 7'd1, 6'd1, 6'd1);
      send_note(8'd3, 8'd34, 9'sd0, MODE_TRACK, 7'd1, 6'd1, 6'd1);
      // global mode: note-on, note-off, release all with no entry
      send_note(8'd5, 8'd40, 9'sd0, MODE_GLOBAL, 7'd8, 6'd2, 6'd4);
      send_note(8'd6, off_code, -9'sd1, MODE_GLOBAL, 7'd8, 6'd2, 6'd4);
      send_note(8'd5, cut_code, 9'sd40, MODE_GLOBAL, 7'd8, 6'd2, 6'd4);
      send_note(8'd5, 8'd41, 9'sd0, MODE_GLOBAL, 7'd8, 6'd2, 6'd4);
      send_note(8'd5, off_code, -9'sd1, MODE_GLOBAL, 7'd8, 6'd2, 6'd4);
   endtask

   task automatic test_list_full();
      // fill all tracks of one instrument, overflow another, then steal
      for (int k = 0; k < LIST_DEPTH; k++)
         send_note(8'd1, play_note(), 9'sd0, MODE_TRACK, 7'd64, 6'($urandom), 6'($urandom));
      send_note(8'd2, play_note(), 9'sd0, MODE_TRACK, 7'd4, 6'($urandom), 6'($urandom));
      send_note(8'd2, play_note(), 9'sd0, MODE_TRACK, 7'd1, 6'($urandom), 6'($urandom));
      send_note(8'd1, play_note(), 9'sd0, MODE_TRACK, 7'd64, 6'($urandom), 6'($urandom));
      send_note(8'd1, play_note(), 9'sd0, MODE_TRACK, 7'd127, 6'($urandom), 6'($urandom));
      send_note(8'd1, off_code, -9'sd1, MODE_TRACK, 7'd64, 6'($urandom), 6'($urandom));
   endtask

   task automatic test_random(input int count);
      logic [7:0]        pid;
      logic [7:0]        note;
      logic signed [8:0] prev;
      logic [1:0]        mode;
      logic [6:0]        tc;
      int                pick;
      int                sn;
      for (int k = 0; k < count; k++) begin
         pid  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
         tc   = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(12, 1));
         mode = ($urandom_range(19) == 0) ? 2'($urandom) :
                ($urandom_range(14) == 0) ? MODE_GLOBAL : MODE_TRACK;
         prev = 9'($urandom);
         pick = $urandom_range(99);
         if (pick < 60) begin
            note = play_note();
         end else if (pick < 85) begin
            // release of a sounding note
            sn = sounding_note(pid);
            note = $urandom_range(1) ? off_code : cut_code;
            if (sn >= 0) prev = 9'(sn);
         end else if (pick < 92) begin
            note = $urandom_range(1) ? off_code : cut_code;
            prev = -9'sd1;
         end else begin
            note = 8'($urandom);
         end
         send_note(pid, note, prev, mode, tc, 6'($urandom), 6'($urandom));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      voice_result_type x;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: acc %0d group %0d track %0d",
                     $time, rsp_accepted, rsp_out_group, rsp_out_track);
            mismatch_count++;
         end else begin
            x = pending_results.pop_front();
            if (rsp_accepted !== x.acc || rsp_out_group !== x.grp ||
                rsp_out_track !== x.trk || rsp_out_note_column !== x.ncol ||
                rsp_out_velocity_column !== x.vcol || rsp_overflow !== x.ovf) begin
               $display("%0t: expected acc %0d grp %0d trk %0d ncol %0d vcol %0d ovf %0d",
                        $time, x.acc, x.grp, x.trk, x.ncol, x.vcol, x.ovf);
               $display("%0t: actual   acc %0d grp %0d trk %0d ncol %0d vcol %0d ovf %0d",
                        $time, rsp_accepted, rsp_out_group, rsp_out_track,
                        rsp_out_note_column, rsp_out_velocity_column, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout waiting for a beat", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_plugin_id = '0;
      req_note = '0;
      req_prev_note = '0;
      req_group_mode = '0;
      req_track_count = '0;
      req_note_column = '0;
      req_velocity_column = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      off_code = 8'd255;
      cut_code = 8'd254;
      mismatch_count = 0;
      item_count = 0;
      result_count = 0;
      overflow_count = 0;
      quiet_cycles = 0;
      idle_enable = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_list_full();
      // long stretch without idling
      test_random(350);
      idle_enable = 1'b1;
      write_code(CSR_NOTE_OFF, 8'd0);
      write_code(CSR_NOTE_CUT, 8'd255);
      test_directed();
      test_random(350);
      write_code(CSR_NOTE_OFF, 8'($urandom));
      write_code(CSR_NOTE_CUT, 8'($urandom));
      test_list_full();
      test_random(350);
      write_code(CSR_NOTE_OFF, 8'd254);
      write_code(CSR_NOTE_CUT, 8'd0);
      test_random(350);
      drain_block();

      $display("covered %0d note beats, %0d results, %0d list overflows, four code settings",
               item_count, result_count, overflow_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
